// ----- rtl/wse_pkg.sv -----
// Shared types and constants for the WS2812 SPI bit encoder.
// Used by the front classifier, the command queue, the serialiser and the top level.
`default_nettype none

package wse_pkg;

   // Reset values of the configuration registers.
   localparam logic [15:0] ZERO_CODE_RST   = 16'h7000;
   localparam logic [15:0] ONE_CODE_RST    = 16'h7F00;
   localparam logic [15:0] LATCH_WORD_RST  = 16'h00FF;
   localparam logic [4:0]  RESET_COUNT_RST = 5'd20;

   // Register indexes on the configuration port.
   localparam int unsigned  CSR_INDEX_W     = 2;
   localparam logic [1:0]   REG_ZERO_CODE   = 2'd0;
   localparam logic [1:0]   REG_ONE_CODE    = 2'd1;
   localparam logic [1:0]   REG_LATCH_WORD  = 2'd2;
   localparam logic [1:0]   REG_RESET_COUNT = 2'd3;

   // Request kinds carried on the input tuser.
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_LATCH = 1'b1;

   // Words per pixel and the ceiling on latch words.
   localparam logic [4:0] BITS_PER_PIXEL = 5'd24;
   localparam logic [4:0] MAX_LATCH      = 5'd24;

   // One classified command, as queued between front and back.
   typedef struct packed {
      logic        is_latch;
      logic [23:0] bits;
      logic [4:0]  count;
   } cmd_type;

endpackage : wse_pkg

`default_nettype wire

// ----- rtl/wse_front.sv -----
// Front end: accepts requests and turns them into serialiser commands.
// Depends on wse_pkg for the command type and constants.
`default_nettype none

module wse_front
   import wse_pkg::*;
(
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic [4:0]  reset_count,
   input  wire logic        queue_full,
   output      logic        push,
   output      cmd_type     push_cmd
);

   logic [7:0] green;
   logic [7:0] red;
   logic [7:0] blue;
   logic [4:0] latch_count;

   // Channels are widened by placing them in the top bits of a byte.
   assign green = {req_tdata[10:5], 2'b00};
   assign red   = {req_tdata[15:11], 3'b000};
   assign blue  = {req_tdata[4:0], 3'b000};

   always_comb begin
      if (reset_count == 5'd0) begin
         latch_count = 5'd1;
      end else if (reset_count > MAX_LATCH) begin
         latch_count = MAX_LATCH;
      end else begin
         latch_count = reset_count;
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_cmd.is_latch = (req_tuser == REQ_LATCH);
      push_cmd.bits     = {green, red, blue};
      push_cmd.count    = (req_tuser == REQ_LATCH) ? latch_count : BITS_PER_PIXEL;
   end

endmodule : wse_front

`default_nettype wire

// ----- rtl/wse_queue.sv -----
// Short command queue between the front end and the serialiser.
// Depends on wse_pkg for the command type.
`default_nettype none

module wse_queue
   import wse_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output      logic    full,
   output      logic    not_empty,
   input  wire logic    pop,
   output      cmd_type head_cmd
);

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The fill level never goes beyond the number of entries.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue fill level exceeds depth");

   // The serialiser only takes a command that is present.
   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule : wse_queue

`default_nettype wire

// ----- rtl/wse_back.sv -----
// Back end: serialises queued commands into SPI half-words behind an output register.
// Depends on wse_pkg for the command type.
`default_nettype none

module wse_back
   import wse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output      logic        pop,
   input  wire logic [15:0] zero_code,
   input  wire logic [15:0] one_code,
   input  wire logic [15:0] latch_word,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,
   output      logic        rsp_tlast
);

   logic        active_ff;
   logic        active_in;
   logic        is_latch_ff;
   logic        is_latch_in;
   logic [23:0] shift_ff;
   logic [23:0] shift_in;
   logic [4:0]  remaining_ff;
   logic [4:0]  remaining_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;
   logic        word_fire;
   logic        finishing;

   // An active command loads a word whenever the output register is free or drains.
   assign word_fire = active_ff && (!rsp_valid_ff || rsp_tready);
   assign finishing = word_fire && (remaining_ff == 5'd1);
   assign pop       = cmd_valid && (!active_ff || finishing);

   always_comb begin
      active_in    = active_ff;
      is_latch_in  = is_latch_ff;
      shift_in     = shift_ff;
      remaining_in = remaining_ff;
      if (pop) begin
         active_in    = 1'b1;
         is_latch_in  = cmd.is_latch;
         shift_in     = cmd.bits;
         remaining_in = cmd.count;
      end else if (word_fire) begin
         active_in    = !finishing;
         shift_in     = {shift_ff[22:0], 1'b0};
         remaining_in = remaining_ff - 5'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (word_fire) begin
         rsp_valid_in = 1'b1;
         if (is_latch_ff) begin
            rsp_data_in = latch_word;
         end else begin
            rsp_data_in = shift_ff[23] ? one_code : zero_code;
         end
         rsp_last_in = (remaining_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_latch_ff  <= is_latch_in;
      shift_ff     <= shift_in;
      remaining_ff <= remaining_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // While a command is being worked on, its word count is never spent or oversized.
   a_remaining_range : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (remaining_ff != 5'd0) && (remaining_ff <= MAX_LATCH))
      else $error("word count out of range while active");

   // The serialiser goes idle only after loading the final word of a command.
   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(active_ff)) |-> (rsp_valid_ff && rsp_last_ff))
      else $error("serialiser went idle without a final word");

endmodule : wse_back

`default_nettype wire

// ----- rtl/ws2812_spi_bit_encoder.sv -----
// Top level of the WS2812 SPI bit encoder: configuration registers and the
// front end, command queue and serialiser. Depends on wse_pkg and the wse_* modules.
`default_nettype none

// Channel   Direction  Payload
// req_*     in         tdata[15:0] = color (RGB565), tuser[0] = req_type
// rsp_*     out        tdata[15:0] = spi_word, tlast = last
// csr_*     in         index[1:0] = register, data[15:0] = value
//
// A pixel transaction produces 24 words at one word per cycle while rsp_tready is
// held high; an end-of-frame transaction produces 1 to 24 latch words. The
// serialiser's output register sets this rate.
// The queue lets the front end accept further transactions while the back end works,
// and a stalled rsp side holds its word while new commands keep queuing until the queue is full.
// Reset is synchronous and active high; it restores the register defaults and
// empties the queue and the output register.

module ws2812_spi_bit_encoder
   import wse_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input channel.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [15:0]            req_tdata,   // [15:0] color
   input  wire logic                   req_tuser,   // [0] req_type
   // Result channel.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [15:0]            rsp_tdata,   // [15:0] spi_word
   output      logic                   rsp_tlast,
   // Configuration write channel.
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_data
);

   logic [15:0] zero_code_ff;
   logic [15:0] one_code_ff;
   logic [15:0] latch_word_ff;
   logic [4:0]  reset_count_ff;
   logic        csr_write;
   logic        queue_full;
   logic        queue_not_empty;
   logic        push;
   logic        pop;
   cmd_type     push_cmd;
   cmd_type     head_cmd;

   // Register writes are always accepted; the host must write only while the block is idle, which is not checked.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_code_ff   <= ZERO_CODE_RST;
         one_code_ff    <= ONE_CODE_RST;
         latch_word_ff  <= LATCH_WORD_RST;
         reset_count_ff <= RESET_COUNT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_ZERO_CODE: begin
               zero_code_ff <= csr_data;
            end
            REG_ONE_CODE: begin
               one_code_ff <= csr_data;
            end
            REG_LATCH_WORD: begin
               latch_word_ff <= csr_data;
            end
            REG_RESET_COUNT: begin
               reset_count_ff <= csr_data[4:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each transaction into a bit pattern or a latch run.
   wse_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .reset_count (reset_count_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   wse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head_cmd  (head_cmd)
   );

   // The back end picks up the next command in the cycle the current one finishes,
   // so consecutive transactions leave without a gap.
   wse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_not_empty),
      .cmd        (head_cmd),
      .pop        (pop),
      .zero_code  (zero_code_ff),
      .one_code   (one_code_ff),
      .latch_word (latch_word_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : ws2812_spi_bit_encoder

`default_nettype wire

// ----- verif/ws2812_spi_bit_encoder_tb.sv -----
// Self-checking testbench for the WS2812 SPI bit encoder: directed and random pixel and
// end-of-frame transactions under several register settings, checked word by word.
// Depends on wse_pkg and the ws2812_spi_bit_encoder RTL; needs no files or arguments.
`default_nettype none

module ws2812_spi_bit_encoder_tb;
   import wse_pkg::*;

   // A run far beyond the slowest correct one ends here.
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned RANDOM_PER_SETTING = 56;
   localparam int unsigned SETTING_COUNT = 9;

   // One transaction waiting to be offered on the request channel.
   typedef struct {
      logic        kind;
      logic [15:0] color;
   } frame_item_type;

   // One register write waiting to be offered on the configuration channel.
   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [15:0]            value;
   } reg_write_type;

   // One SPI half-word that the block owes us.
   typedef struct {
      logic [15:0] word;
      logic        last;
   } spi_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic                   req_tuser = REQ_PIXEL;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_data = '0;

   ws2812_spi_bit_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Our own copy of the configuration registers, updated when a write is accepted.
   logic [15:0] zero_code_copy  = ZERO_CODE_RST;
   logic [15:0] one_code_copy   = ONE_CODE_RST;
   logic [15:0] latch_word_copy = LATCH_WORD_RST;
   logic [4:0]  latch_count_raw = RESET_COUNT_RST;

   frame_item_type items_to_send[$];
   reg_write_type  writes_to_send[$];
   spi_word_type   words_due[$];
   spi_word_type   oldest_due;
   frame_item_type next_item;
   reg_write_type  next_write;

   int unsigned items_queued    = 0;
   int unsigned items_accepted  = 0;
   int unsigned writes_queued   = 0;
   int unsigned writes_accepted = 0;
   int unsigned words_seen      = 0;
   int unsigned mismatches      = 0;
   int unsigned cycles          = 0;
   int unsigned req_idle_pct    = 0;
   int unsigned rsp_idle_pct    = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d, word %0d: %s", cycles, words_seen, what);
      mismatches++;
   endtask

   // Works out the half-words that one accepted transaction must produce. A pixel
   // expands each RGB565 channel to a byte with zero low bits and goes out as
   // green, red, blue, most significant bit first; an end-of-frame transaction
   // repeats the latch word, with a zero count raised to one and large counts
   // clipped to the ceiling. The colour field is ignored on end of frame.
   task automatic predict_spi_words(input logic kind, input logic [15:0] color);
      logic [23:0]  grb;
      logic [4:0]   latch_total;
      spi_word_type w;
      int           i;
      if (kind == REQ_PIXEL) begin
         grb = {color[10:5], 2'b00, color[15:11], 3'b000, color[4:0], 3'b000};
         for (i = 23; i >= 0; i--) begin
            w.word = grb[i] ? one_code_copy : zero_code_copy;
            w.last = (i == 0);
            words_due.push_back(w);
         end
      end else begin
         latch_total = latch_count_raw;
         if (latch_total == 5'd0)
            latch_total = 5'd1;
         if (latch_total > MAX_LATCH)
            latch_total = MAX_LATCH;
         for (i = 1; i <= int'(latch_total); i++) begin
            w.word = latch_word_copy;
            w.last = (i == int'(latch_total));
            words_due.push_back(w);
         end
      end
   endtask

   // Only the low five bits of a count write survive; the rest are dropped.
   task automatic apply_register(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] value);
      case (index)
         REG_ZERO_CODE:   zero_code_copy  = value;
         REG_ONE_CODE:    one_code_copy   = value;
         REG_LATCH_WORD:  latch_word_copy = value;
         REG_RESET_COUNT: latch_count_raw = value[4:0];
         default: ;
      endcase
   endtask

   // Request and configuration driver. Handshakes are judged on the values held
   // before the edge; a new transaction is loaded only once the current one has
   // gone, so each valid gets a single nonblocking assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_spi_words(req_tuser, req_tdata);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               next_item = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_item.kind;
               req_tdata  <= next_item.color;
            end else begin
               req_tvalid <= 1'b0;
            end
         end

         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            writes_accepted++;
         end
         if (!csr_valid || csr_ready) begin
            if (writes_to_send.size() != 0) begin
               next_write = writes_to_send.pop_front();
               csr_valid <= 1'b1;
               csr_index <= next_write.index;
               csr_data  <= next_write.value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every word taken off the result channel is matched against
   // the oldest outstanding expectation, and tready is stalled at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (words_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               oldest_due = words_due.pop_front();
               if (rsp_tdata !== oldest_due.word)
                  report_mismatch($sformatf("spi_word %h, expected %h",
                                            rsp_tdata, oldest_due.word));
               if (rsp_tlast !== oldest_due.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_tlast, oldest_due.last));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Watchdog: a hung block or a lost word ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_item(input logic kind, input logic [15:0] color);
      frame_item_type it;
      it.kind  = kind;
      it.color = color;
      items_to_send.push_back(it);
      items_queued++;
   endtask

   task automatic queue_write(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] value);
      reg_write_type wr;
      wr.index = index;
      wr.value = value;
      writes_to_send.push_back(wr);
      writes_queued++;
   endtask

   // Returns once every queued transaction and register write has been accepted and every
   // word the transactions caused has arrived; the block is then idle, since each transaction yields words.
   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (items_accepted != items_queued || writes_accepted != writes_queued ||
             words_due.size() != 0);
   endtask

   // Mostly pixels with random colour; now and then an end-of-frame transaction
   // carrying a random colour that the block must ignore.
   task automatic queue_random_items(input int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15)
            queue_item(REQ_LATCH, 16'($urandom_range(0, 65535)));
         else
            queue_item(REQ_PIXEL, 16'($urandom_range(0, 65535)));
      end
   endtask

   logic [15:0] count_value;
   int unsigned setting;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: colour extremes, each channel alone, the top and bottom
      // bit of every channel, alternating patterns, and end of frame with the
      // colour field both clear and full.
      req_idle_pct = 17;
      rsp_idle_pct = 54;
      queue_item(REQ_PIXEL, 16'h0000);
      queue_item(REQ_PIXEL, 16'hFFFF);
      queue_item(REQ_PIXEL, 16'hF800);
      queue_item(REQ_PIXEL, 16'h07E0);
      queue_item(REQ_PIXEL, 16'h001F);
      queue_item(REQ_PIXEL, 16'h8410);
      queue_item(REQ_PIXEL, 16'h0821);
      queue_item(REQ_PIXEL, 16'hAAAA);
      queue_item(REQ_PIXEL, 16'h5555);
      queue_item(REQ_LATCH, 16'h0000);
      queue_item(REQ_LATCH, 16'hFFFF);
      queue_random_items(RANDOM_PER_SETTING);
      wait_until_drained();

      // Each setting rewrites all four registers while the block is idle. The
      // count takes a zero (raised to one), the ceiling, values above it, a value whose upper
      // bits must be dropped, one, a random value, and at the end the default.
      for (setting = 1; setting < SETTING_COUNT; setting++) begin
         if (setting < 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 54;
         end else if (setting < 6) begin
            req_idle_pct = 54;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         case (setting)
            1: count_value = 16'h0000;
            2: count_value = 16'h0018;
            3: count_value = 16'h0019;
            4: count_value = 16'h001F;
            5: count_value = 16'hFFE1;
            6: count_value = 16'h0001;
            7: count_value = 16'($urandom_range(0, 65535));
            default: count_value = {11'd0, RESET_COUNT_RST};
         endcase

         if (setting == 1) begin
            queue_write(REG_ZERO_CODE, 16'h0000);
            queue_write(REG_ONE_CODE, 16'hFFFF);
            queue_write(REG_LATCH_WORD, 16'h0000);
         end else if (setting == 2) begin
            queue_write(REG_ZERO_CODE, 16'hFFFF);
            queue_write(REG_ONE_CODE, 16'h0000);
            queue_write(REG_LATCH_WORD, 16'hFFFF);
         end else if (setting == SETTING_COUNT - 1) begin
            queue_write(REG_ZERO_CODE, ZERO_CODE_RST);
            queue_write(REG_ONE_CODE, ONE_CODE_RST);
            queue_write(REG_LATCH_WORD, LATCH_WORD_RST);
         end else begin
            queue_write(REG_ZERO_CODE, 16'($urandom_range(0, 65535)));
            queue_write(REG_ONE_CODE, 16'($urandom_range(0, 65535)));
            queue_write(REG_LATCH_WORD, 16'($urandom_range(0, 65535)));
         end
         queue_write(REG_RESET_COUNT, count_value);
         wait_until_drained();

         queue_item(REQ_LATCH, 16'($urandom_range(0, 65535)));
         queue_item(REQ_PIXEL, 16'hFFFF);
         queue_item(REQ_PIXEL, 16'h0000);
         queue_random_items(RANDOM_PER_SETTING / 2);
         // The sender holds off here until every outstanding word has come back.
         wait_until_drained();
         queue_random_items(RANDOM_PER_SETTING / 2);
         wait_until_drained();
      end

      // Give any stray extra word time to show up before the verdict.
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule : ws2812_spi_bit_encoder_tb

`default_nettype wire
